/* sv/ppc_pkg.sv */
package ppc_pkg;

    // field widths
    localparam int CFG_W       = 32;
    localparam int EPS_W       = 31;
    localparam int FRAC_W      = 16;
    localparam int FACE_W      = 16;
    localparam int VIDX_W      = 12;
    localparam int CFG_IDX_W   = 3;

    // position sign is taken at this width
    localparam int COORD_WIDTH = 32;

    // distance arithmetic widths
    localparam int PROD_W      = CFG_W + COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 1;
    localparam int DIST_W      = PROD_W + 2;
    localparam int OFF_W       = CFG_W + FRAC_W;

    // tag cache
    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int EPOCH_W      = 6;

    // queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // register reset values
    localparam logic signed [CFG_W-1:0] NORMAL_Z_RESET = 32'sh0001_0000;
    localparam logic [EPS_W-1:0]        EPSILON_RESET  = 31'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_EPSILON  = 3'd4
    } t_cfg_idx;

    typedef enum logic [0:0] {
        CMD_CLASSIFY = 1'b0,
        CMD_CLEAR    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_ON   = 2'd1,
        TAG_OUT  = 2'd2,
        TAG_IN   = 2'd3
    } t_tag;

    typedef enum logic [2:0] {
        RUN_IN   = 3'd0,
        RUN_OUT  = 3'd1,
        RUN_ON   = 3'd2,
        RUN_SPAN = 3'd3,
        RUN_NONE = 3'd4
    } t_run;

    typedef struct packed {
        logic                      command;
        logic [FACE_W-1:0]         face_index;
        logic [VIDX_W-1:0]         vertex_index;
        logic signed [CFG_W-1:0]   pos_x;
        logic signed [CFG_W-1:0]   pos_y;
        logic signed [CFG_W-1:0]   pos_z;
        logic                      last_vertex;
    } t_in;

    typedef struct packed {
        logic [FACE_W-1:0] out_face_index;
        logic [VIDX_W-1:0] out_vertex_index;
        logic [1:0]        vertex_class;
        logic              newly_tagged;
        logic [1:0]        polygon_class;
        logic              polygon_done;
    } t_out;

    // one request after distance classification
    typedef struct packed {
        logic              command;
        logic [FACE_W-1:0] face_index;
        logic [VIDX_W-1:0] vertex_index;
        logic              last_vertex;
        t_tag              dist_tag;
    } t_work;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        t_tag               tag;
    } t_tag_entry;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } t_queue_stat;

endpackage

/* sv/ppc_ram.sv */
module ppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ppc_front.sv */
module ppc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppc_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    input  ppc_pkg::t_in                       i_in,
    output logic                               o_in_ready,
    input  ppc_pkg::t_queue_stat               i_q_stat,
    output logic                               o_push,
    output ppc_pkg::t_work                     o_push_data
);

    localparam int CNT_W = ppc_pkg::QCNT_W + 1;

    logic signed [ppc_pkg::CFG_W-1:0]  r_nx, r_ny, r_nz, r_offset;
    logic [ppc_pkg::EPS_W-1:0]         r_eps;

    logic                               r_v1, r_v2;
    ppc_pkg::t_work                     r_w1, r_w2;
    logic signed [ppc_pkg::PROD_W-1:0]  r_p_x, r_p_y, r_p_z;
    logic signed [ppc_pkg::OFF_W-1:0]   r_off;
    logic signed [ppc_pkg::SUM_W-1:0]   r_sum_a, r_sum_b;

    logic                               accept;
    logic [CNT_W-1:0]                   inflight;
    logic signed [ppc_pkg::COORD_WIDTH-1:0] px, py, pz;
    logic signed [ppc_pkg::PROD_W-1:0]  n_p_x, n_p_y, n_p_z;
    logic signed [ppc_pkg::SUM_W-1:0]   n_sum_a, n_sum_b;
    logic signed [ppc_pkg::DIST_W-1:0]  plane_dist, eps_s, neg_eps_s;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx     <= '0;
            r_ny     <= '0;
            r_nz     <= ppc_pkg::NORMAL_Z_RESET;
            r_offset <= '0;
            r_eps    <= ppc_pkg::EPSILON_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppc_pkg::CFG_NORMAL_X: r_nx     <= i_cfg_data;
                ppc_pkg::CFG_NORMAL_Y: r_ny     <= i_cfg_data;
                ppc_pkg::CFG_NORMAL_Z: r_nz     <= i_cfg_data;
                ppc_pkg::CFG_OFFSET:   r_offset <= i_cfg_data;
                ppc_pkg::CFG_EPSILON:  r_eps    <= i_cfg_data[ppc_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // accept only while the queue has room for everything in flight
    assign inflight = CNT_W'(i_q_stat.count) + CNT_W'(r_v1) + CNT_W'(r_v2);
    assign o_in_ready = inflight < CNT_W'(ppc_pkg::QUEUE_DEPTH);
    assign accept = i_in_valid && o_in_ready;

    // stage 1: three products
    assign px = i_in.pos_x[ppc_pkg::COORD_WIDTH-1:0];
    assign py = i_in.pos_y[ppc_pkg::COORD_WIDTH-1:0];
    assign pz = i_in.pos_z[ppc_pkg::COORD_WIDTH-1:0];
    assign n_p_x = r_nx * px;
    assign n_p_y = r_ny * py;
    assign n_p_z = r_nz * pz;

    // stage 2: pairwise sums
    assign n_sum_a = ppc_pkg::SUM_W'(r_p_x) + ppc_pkg::SUM_W'(r_p_y);
    assign n_sum_b = ppc_pkg::SUM_W'(r_p_z) + ppc_pkg::SUM_W'(r_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1.command      <= i_in.command;
        r_w1.face_index   <= i_in.face_index;
        r_w1.vertex_index <= i_in.vertex_index;
        r_w1.last_vertex  <= i_in.last_vertex;
        r_w1.dist_tag     <= ppc_pkg::TAG_NONE;
        r_p_x             <= n_p_x;
        r_p_y             <= n_p_y;
        r_p_z             <= n_p_z;
        r_off             <= {r_offset, {ppc_pkg::FRAC_W{1'b0}}};
        r_w2              <= r_w1;
        r_sum_a           <= n_sum_a;
        r_sum_b           <= n_sum_b;
    end

    // final add and compare against the on-plane band
    assign plane_dist = ppc_pkg::DIST_W'(r_sum_a) + ppc_pkg::DIST_W'(r_sum_b);
    assign eps_s      = ppc_pkg::DIST_W'({r_eps, {ppc_pkg::FRAC_W{1'b0}}});
    assign neg_eps_s  = -eps_s;

    always_comb begin
        o_push_data = r_w2;
        priority if (plane_dist <= eps_s && plane_dist >= neg_eps_s) begin
            o_push_data.dist_tag = ppc_pkg::TAG_ON;
        end else if (plane_dist > ppc_pkg::DIST_W'(0)) begin
            o_push_data.dist_tag = ppc_pkg::TAG_OUT;
        end else begin
            o_push_data.dist_tag = ppc_pkg::TAG_IN;
        end
    end

    assign o_push = r_v2;

endmodule

/* sv/ppc_queue.sv */
module ppc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ppc_pkg::t_work        i_push_data,
    input  logic                  i_pop,
    output ppc_pkg::t_work        o_head,
    output ppc_pkg::t_queue_stat  o_stat
);

    ppc_pkg::t_work              r_mem [ppc_pkg::QUEUE_DEPTH];
    logic [ppc_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [ppc_pkg::QCNT_W-1:0]  r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.valid = r_count != '0;
    assign o_stat.count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != ppc_pkg::QCNT_W'(ppc_pkg::QUEUE_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.valid)
        else $error("queue underflow");

endmodule

/* sv/ppc_back.sv */
module ppc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppc_pkg::t_work        i_head,
    input  ppc_pkg::t_queue_stat  i_q_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ppc_pkg::t_out         o_out
);

    localparam int ENTRY_W = $bits(ppc_pkg::t_tag_entry);

    // work stage
    logic                        r_b_valid;
    ppc_pkg::t_work              r_b;
    logic                        r_fwd_hit;
    ppc_pkg::t_tag               r_fwd_tag;

    // cache epoch and clearing sweep
    logic [ppc_pkg::EPOCH_W-1:0] r_epoch;
    logic                        r_sweep;
    logic [ppc_pkg::ADDR_W-1:0]  r_sweep_addr;

    // running fold
    ppc_pkg::t_run               r_running;
    logic [1:0]                  r_on_cnt;

    // output register
    logic                        r_out_valid;
    ppc_pkg::t_out               r_out;

    logic                        b_leave, b_enter, is_clear, in_range, cached;
    logic                        b_write, sweep_start;
    logic [ppc_pkg::ADDR_W-1:0]  b_addr, head_addr;
    ppc_pkg::t_tag_entry         ram_rdata, ram_wdata;
    logic                        ram_we;
    logic [ppc_pkg::ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0]          ram_rbits;
    ppc_pkg::t_tag               hit_tag, tag;
    ppc_pkg::t_run               run_new, run_tag;
    logic [1:0]                  cnt_new;
    ppc_pkg::t_out               n_out;
    ppc_pkg::t_run               n_running;
    logic [1:0]                  n_on_cnt;

    assign b_leave   = r_b_valid && (!r_out_valid || i_out_ready);
    assign is_clear  = r_b.command == ppc_pkg::CMD_CLEAR;
    assign in_range  = int'(r_b.vertex_index) < ppc_pkg::MAX_VERTICES;
    assign b_addr    = ppc_pkg::ADDR_W'(r_b.vertex_index);
    assign head_addr = ppc_pkg::ADDR_W'(i_head.vertex_index);

    // a clear that wraps the epoch starts a sweep and holds the stage empty
    assign sweep_start = b_leave && is_clear && (r_epoch == '1);
    assign b_enter = i_q_stat.valid && !r_sweep && !sweep_start && (!r_b_valid || b_leave);
    assign o_pop   = b_enter;

    // cached tag lookup with forwarding of the previous write
    assign ram_rdata = ram_rbits;
    always_comb begin
        if (r_fwd_hit) begin
            hit_tag = r_fwd_tag;
        end else if (ram_rdata.epoch == r_epoch) begin
            hit_tag = ram_rdata.tag;
        end else begin
            hit_tag = ppc_pkg::TAG_NONE;
        end
        cached = in_range && (hit_tag != ppc_pkg::TAG_NONE);
        tag    = cached ? hit_tag : r_b.dist_tag;
    end

    // tag cache write or sweep
    assign b_write         = b_leave && !is_clear && in_range && !cached;
    assign ram_we          = r_sweep || b_write;
    assign ram_waddr       = r_sweep ? r_sweep_addr : b_addr;
    assign ram_wdata.epoch = r_sweep ? '0 : r_epoch;
    assign ram_wdata.tag   = r_sweep ? ppc_pkg::TAG_NONE : tag;

    ppc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ppc_pkg::MAX_VERTICES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (b_enter),
        .i_raddr (head_addr),
        .o_rdata (ram_rbits)
    );

    // polygon fold and result
    always_comb begin
        unique case (tag)
            ppc_pkg::TAG_ON:  run_tag = ppc_pkg::RUN_ON;
            ppc_pkg::TAG_OUT: run_tag = ppc_pkg::RUN_OUT;
            default:          run_tag = ppc_pkg::RUN_IN;
        endcase

        priority if (r_running == ppc_pkg::RUN_NONE || r_running == ppc_pkg::RUN_ON) begin
            run_new = run_tag;
        end else if (r_running == ppc_pkg::RUN_IN && tag == ppc_pkg::TAG_OUT) begin
            run_new = ppc_pkg::RUN_SPAN;
        end else if (r_running == ppc_pkg::RUN_OUT && tag == ppc_pkg::TAG_IN) begin
            run_new = ppc_pkg::RUN_SPAN;
        end else begin
            run_new = r_running;
        end

        cnt_new = (tag == ppc_pkg::TAG_ON && r_on_cnt != 2'd3) ? r_on_cnt + 2'd1 : r_on_cnt;

        n_out.out_face_index   = r_b.face_index;
        n_out.out_vertex_index = r_b.vertex_index;
        n_out.vertex_class     = 2'(tag) - 2'd1;
        n_out.newly_tagged     = !cached;
        n_out.polygon_class    = 2'd0;
        n_out.polygon_done     = 1'b0;
        n_running              = run_new;
        n_on_cnt               = cnt_new;

        if (is_clear) begin
            n_out.vertex_class = 2'd0;
            n_out.newly_tagged = 1'b0;
            n_running          = r_running;
            n_on_cnt           = r_on_cnt;
        end else if (r_b.last_vertex) begin
            n_out.polygon_class = (cnt_new > 2'd2) ? 2'(ppc_pkg::RUN_ON) : 2'(run_new);
            n_out.polygon_done  = 1'b1;
            n_running           = ppc_pkg::RUN_NONE;
            n_on_cnt            = 2'd0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_epoch      <= '0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_running    <= ppc_pkg::RUN_NONE;
            r_on_cnt     <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_b_valid   <= b_enter || (r_b_valid && !b_leave);
            r_out_valid <= b_leave || (r_out_valid && !i_out_ready);

            if (b_enter) begin
                r_fwd_hit <= b_write && (b_addr == head_addr);
            end else if (b_leave) begin
                r_fwd_hit <= 1'b0;
            end

            if (b_leave) begin
                r_running <= n_running;
                r_on_cnt  <= n_on_cnt;
                if (is_clear) begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end

            if (sweep_start) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
                if (r_sweep_addr == ppc_pkg::ADDR_W'(ppc_pkg::MAX_VERTICES - 1)) begin
                    r_sweep <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (b_enter) begin
            r_b       <= i_head;
            r_fwd_tag <= tag;
        end
        if (b_leave) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !r_b_valid)
        else $error("work stage busy during tag sweep");

    a_fwd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_b_valid)
        else $error("forwarded tag without a request in the work stage");

    a_tag_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !r_sweep) |->
            (ram_wdata.tag != ppc_pkg::TAG_NONE && ram_wdata.epoch == r_epoch))
        else $error("bad tag cache write");

endmodule

/* sv/polygon_plane_classifier_core.sv */
// Polygon plane classifier: one vertex request per clock in steady state while
// results are taken. A request takes two pipeline stages for the exact signed
// Q50.16 distance (three 32x32 products, then two pairwise sums, then a final add
// with the on-plane compare), passes an eight-entry queue, and enters the back
// stage, where the vertex tag cache (one RAM read and at most one write per
// request, forwarded between neighbors) and the polygon fold run; the result then
// sits in an output register. Input ready drops only when the queue cannot take
// everything in flight. After reset, and after every 64th clear command, the back
// stage sweeps the 4096-entry tag RAM; requests are still accepted until the queue
// fills, and results resume when the sweep ends. Configuration must be written by
// the user only while the block is idle; the block itself does not enforce it.
module polygon_plane_classifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ppc_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ppc_pkg::t_out                  o_out
);

    logic                  push, pop;
    ppc_pkg::t_work        push_data, head;
    ppc_pkg::t_queue_stat  q_stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // distance classification
    ppc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_ready  (o_in_ready),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decoupling queue
    ppc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // tag cache, fold and output register
    ppc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* tb/tb_polygon_plane_classifier_core.sv */
module tb_polygon_plane_classifier_core;
    import ppc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 180;
    localparam int DRAIN_CYCLES  = 64;

    // vertex class codes on the result
    localparam logic [1:0] VC_ON  = 2'd0;
    localparam logic [1:0] VC_OUT = 2'd1;
    localparam logic [1:0] VC_IN  = 2'd2;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out;

    // plane registers as last written
    logic signed [CFG_W-1:0] normal_x = '0;
    logic signed [CFG_W-1:0] normal_y = '0;
    logic signed [CFG_W-1:0] normal_z = NORMAL_Z_RESET;
    logic signed [CFG_W-1:0] offset   = '0;
    logic [EPS_W-1:0]        epsilon  = EPSILON_RESET;

    // vertex tag cache and running face fold
    t_tag tag_cache [MAX_VERTICES];
    t_run face_fold = RUN_NONE;
    int   on_tally  = 0;

    t_in  vertex_feed [$];
    t_out predicted   [$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int stall_cycles   = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int faces_closed   = 0;
    int clears_sent    = 0;
    int cache_hits     = 0;
    int settings_used  = 1;

    polygon_plane_classifier_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // append one request to the pending feed
    task automatic feed_vertex(t_in v);
        vertex_feed.insert(vertex_feed.size(), v);
    endtask

    // side of the plane from the exact Q50.16 distance
    function automatic t_tag plane_side(t_in v);
        logic signed [127:0] nx, ny, nz, px, py, pz, off, signed_dist, mag, tol;
        nx   = normal_x;
        ny   = normal_y;
        nz   = normal_z;
        px   = $signed(v.pos_x);
        py   = $signed(v.pos_y);
        pz   = $signed(v.pos_z);
        off  = offset;
        signed_dist = nx * px + ny * py + nz * pz + (off <<< FRAC_W);
        mag  = (signed_dist < 0) ? -signed_dist : signed_dist;
        tol  = 128'(epsilon) << FRAC_W;
        if (mag <= tol)
            return TAG_ON;
        return (signed_dist < 0) ? TAG_IN : TAG_OUT;
    endfunction

    // tag lookup, face fold and the expected result of one request
    function automatic t_out classify_and_fold(t_in item);
        t_out res;
        t_tag tag;
        res                  = '0;
        res.out_face_index   = item.face_index;
        res.out_vertex_index = item.vertex_index;
        if (item.command == CMD_CLEAR) begin
            foreach (tag_cache[i]) tag_cache[i] = TAG_NONE;
            clears_sent++;
            return res;
        end
        tag = tag_cache[item.vertex_index];
        if (tag == TAG_NONE) begin
            tag = plane_side(item);
            tag_cache[item.vertex_index] = tag;
            res.newly_tagged = 1'b1;
        end else begin
            cache_hits++;
        end
        case (tag)
            TAG_ON:  res.vertex_class = VC_ON;
            TAG_OUT: res.vertex_class = VC_OUT;
            default: res.vertex_class = VC_IN;
        endcase
        if (tag == TAG_ON && on_tally < 3)
            on_tally++;
        case (face_fold)
            RUN_NONE, RUN_ON: begin
                face_fold = (tag == TAG_ON) ? RUN_ON : (tag == TAG_OUT) ? RUN_OUT : RUN_IN;
            end
            RUN_IN: begin
                if (tag == TAG_OUT)
                    face_fold = RUN_SPAN;
            end
            RUN_OUT: begin
                if (tag == TAG_IN)
                    face_fold = RUN_SPAN;
            end
            default: ;
        endcase
        // face end: more than two on vertices make the face on
        if (item.last_vertex) begin
            res.polygon_class = (on_tally > 2) ? 2'(RUN_ON) : 2'(face_fold);
            res.polygon_done  = 1'b1;
            face_fold         = RUN_NONE;
            on_tally          = 0;
            faces_closed++;
        end
        return res;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (predicted.size() == 0) begin
            $error("result with no request pending: face %0d vertex %0d",
                   got.out_face_index, got.out_vertex_index);
            mismatches++;
            return;
        end
        want = predicted.pop_front();
        results_seen++;
        compare_field("out_face_index", want.out_face_index, got.out_face_index);
        compare_field("out_vertex_index", want.out_vertex_index, got.out_vertex_index);
        compare_field("vertex_class", want.vertex_class, got.vertex_class);
        compare_field("newly_tagged", want.newly_tagged, got.newly_tagged);
        compare_field("polygon_class", want.polygon_class, got.polygon_class);
        compare_field("polygon_done", want.polygon_done, got.polygon_done);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                predicted.insert(predicted.size(), classify_and_fold(i_in));
            if (vertex_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in       <= vertex_feed.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out);
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // log-uniform magnitude with random sign, extremes now and then
    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(15))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = '0;
            default: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_in vertex_item(logic [15:0] face, logic [11:0] vidx,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic last);
        t_in v;
        v.command      = CMD_CLASSIFY;
        v.face_index   = face;
        v.vertex_index = vidx;
        v.pos_x        = x;
        v.pos_y        = y;
        v.pos_z        = z;
        v.last_vertex  = last;
        return v;
    endfunction

    function automatic t_in clear_item(logic [15:0] face, logic [11:0] vidx, logic last);
        t_in v;
        v         = vertex_item(face, vidx, random_coord(), random_coord(), random_coord(), last);
        v.command = CMD_CLEAR;
        return v;
    endfunction

    // faces of one to six vertices drawn mostly from a small vertex pool
    task automatic queue_random_faces(int count);
        int          queued;
        int          verts;
        logic [15:0] face;
        logic [11:0] base;
        logic [11:0] vidx;
        t_in         v;
        queued = 0;
        base   = 12'($urandom_range(MAX_VERTICES - 32));
        while (queued < count) begin
            if ($urandom_range(7) == 0) begin
                feed_vertex(clear_item(16'($urandom), 12'($urandom), 1'($urandom)));
                queued++;
            end else begin
                verts = $urandom_range(6, 1);
                face  = 16'($urandom);
                for (int k = 0; k < verts; k++) begin
                    vidx = ($urandom_range(3) == 0) ? 12'($urandom)
                                                    : base + 12'($urandom_range(31));
                    v = vertex_item(face, vidx, random_coord(), random_coord(), random_coord(),
                                    k == verts - 1);
                    // stray or missing face end now and then
                    if ($urandom_range(29) == 0)
                        v.last_vertex = ~v.last_vertex;
                    feed_vertex(v);
                end
                queued += verts;
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_NORMAL_X: normal_x = data;
            CFG_NORMAL_Y: normal_y = data;
            CFG_NORMAL_Z: normal_z = data;
            CFG_OFFSET:   offset   = data;
            CFG_EPSILON:  epsilon  = data[EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] off, logic [EPS_W-1:0] eps);
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_OFFSET, off);
        // top data bit is not part of epsilon
        write_reg(CFG_EPSILON, {1'($urandom), eps});
        settings_used++;
    endtask

    // wait until every request is out and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (vertex_feed.size() != 0 || i_in_valid || predicted.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        foreach (tag_cache[i]) tag_cache[i] = TAG_NONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset plane is z = 0 with an on band of 66 lsb
        // single on vertex face, position extremes on the unused axes
        feed_vertex(vertex_item(16'd0, 12'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 1'b1));
        // band edges: on, just out, on at the lower edge
        feed_vertex(vertex_item(16'd1, 12'd1, 32'd0, 32'd0, 32'd66, 1'b0));
        feed_vertex(vertex_item(16'd1, 12'd2, 32'd0, 32'd0, 32'd67, 1'b0));
        feed_vertex(vertex_item(16'd1, 12'd3, 32'h8000_0000, 32'h7fff_ffff,
                                -32'sd66, 1'b1));
        // all in
        feed_vertex(vertex_item(16'd2, 12'd4, 32'd0, 32'd0, -32'sd67, 1'b0));
        feed_vertex(vertex_item(16'd2, 12'd5, 32'd0, 32'd0, 32'h8000_0000, 1'b1));
        // out then in
        feed_vertex(vertex_item(16'd3, 12'd6, 32'd0, 32'd0, 32'h7fff_ffff, 1'b0));
        feed_vertex(vertex_item(16'd3, 12'd7, 32'd0, 32'd0, -32'sd1000, 1'b1));
        // in then out
        feed_vertex(vertex_item(16'd4, 12'd8, 32'd0, 32'd0, -32'sd5000, 1'b0));
        feed_vertex(vertex_item(16'd4, 12'd9, 32'd0, 32'd0, 32'd5000, 1'b1));
        // three on vertices force on, first one taken from the cache
        feed_vertex(vertex_item(16'd5, 12'd1, 32'd0, 32'd0, 32'd9999, 1'b0));
        feed_vertex(vertex_item(16'd5, 12'd10, 32'd0, 32'd0, 32'd0, 1'b0));
        feed_vertex(vertex_item(16'd5, 12'd11, 32'd0, 32'd0, 32'd1, 1'b0));
        feed_vertex(vertex_item(16'd5, 12'd12, 32'd0, 32'd0, 32'd100, 1'b1));
        // clear in mid face keeps the fold, cleared vertex gets tagged again
        feed_vertex(vertex_item(16'd6, 12'd2, 32'd0, 32'd0, 32'd9999, 1'b0));
        feed_vertex(clear_item(16'hffff, 12'hfff, 1'b1));
        feed_vertex(vertex_item(16'd6, 12'd1, 32'd0, 32'd0, -32'sd500, 1'b1));
        // top indices, second visit reads the cache despite a contrary position
        feed_vertex(vertex_item(16'hffff, 12'hfff, 32'd0, 32'd0, -32'sd67, 1'b1));
        feed_vertex(vertex_item(16'hffff, 12'hfff, 32'd0, 32'd0, 32'd5000, 1'b1));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_plane(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'h8000_0000, '0);
                1: set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                             31'h7fff_ffff);
                default: set_plane(random_coord(), random_coord(), random_coord(),
                                   random_coord(), 31'($urandom >> $urandom_range(31, 1)));
            endcase
            @(negedge i_clk);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 62;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 62;
                end
                default: begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            queue_random_faces(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("checked %0d results over %0d plane settings", results_seen, settings_used);
        $display("%0d faces closed, %0d tag clears, %0d cache hits",
                 faces_closed, clears_sent, cache_hits);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
